@@ hdl/cbd_pkg.sv @@
// Shared types, character codes and a helper function for the chunked body decoder.
`timescale 1ns / 1ps

package cbd_pkg;

   localparam logic [31:0] ChunkSizeLimitReset = 32'h0200_0000;

   localparam logic [7:0] CharCr    = 8'h0D;
   localparam logic [7:0] CharLf    = 8'h0A;
   localparam logic [7:0] CharSpace = 8'h20;
   localparam logic [7:0] CharTab   = 8'h09;
   localparam logic [7:0] CharSemi  = 8'h3B;

   localparam logic [2:0] TermSizeLine = 3'd2;
   localparam logic [2:0] TermFull     = 3'd4;

   typedef enum logic [1:0] {
      STATUS_BUSY  = 2'd0,
      STATUS_DONE  = 2'd1,
      STATUS_ERROR = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      PH_SIZE    = 3'd0,
      PH_SIZE_CR = 3'd1,
      PH_EXT     = 3'd2,
      PH_EXT_CR  = 3'd3,
      PH_DATA    = 3'd4,
      PH_DATA_CR = 3'd5,
      PH_DATA_LF = 3'd6,
      PH_TRAIL   = 3'd7
   } phase_type;

   typedef struct packed {
      logic [7:0] body_byte;
      logic       start_of_body;
   } req_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       data_valid;
      logic [1:0] status;
   } rsp_type;

   // Word held in the input register, as seen by the decode stage.
   typedef struct packed {
      logic    valid;
      req_type item;
   } stage_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.valid = 1'b1;
      h.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.value = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h.value = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h.value = 4'(c - 8'h37);
      end else begin
         h.valid = 1'b0;
      end
      return h;
   endfunction

endpackage

@@ hdl/cbd_in_reg.sv @@
// Input register that holds one body word for the decode stage.
`timescale 1ns / 1ps

module cbd_in_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  cbd_pkg::req_type    req_payload,
   input  logic                advance,
   output cbd_pkg::stage_type  stage
);

   logic             valid_ff, valid_in;
   cbd_pkg::req_type item_ff;
   logic             accept;

   // A new word may enter whenever the register is empty or the held one moves on in the same cycle.
   assign req_ready = !valid_ff || advance;
   assign accept    = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_payload;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

@@ hdl/cbd_decoder.sv @@
// Decode stage: parser state, size limit register and the result register.
`timescale 1ns / 1ps

module cbd_decoder (
   input  logic                clock,
   input  logic                reset,
   input  cbd_pkg::stage_type  stage,
   output logic                advance,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output cbd_pkg::rsp_type    rsp_payload,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [31:0]         csr_wdata
);

   cbd_pkg::phase_type  phase_ff, phase_in, phase_cur;
   cbd_pkg::status_type status_ff, status_in, status_cur;
   logic [31:0] acc_ff, acc_in, acc_cur;
   logic        digit_ff, digit_in, digit_cur;
   logic [31:0] left_ff, left_in, left_cur;
   logic [2:0]  term_ff, term_in, term_cur;
   logic [31:0] limit_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   cbd_pkg::rsp_type rsp_ff, rsp_in;

   logic [7:0]       b;
   logic             sob;
   logic             busy;
   logic             fire;
   logic             line_end;
   logic             data_valid;
   logic [35:0]      acc_next;
   cbd_pkg::hex_type hex;

   assign csr_ready = 1'b1;

   assign advance = !rsp_valid_ff || rsp_ready;
   assign fire    = stage.valid && advance;

   assign b   = stage.item.body_byte;
   assign sob = stage.item.start_of_body;
   assign hex = cbd_pkg::hex_decode(b);

   // Start of body clears the parser before this word is handled.
   always_comb begin
      if (sob) begin
         phase_cur  = cbd_pkg::PH_SIZE;
         status_cur = cbd_pkg::STATUS_BUSY;
         acc_cur    = '0;
         digit_cur  = 1'b0;
         left_cur   = '0;
         term_cur   = '0;
      end else begin
         phase_cur  = phase_ff;
         status_cur = status_ff;
         acc_cur    = acc_ff;
         digit_cur  = digit_ff;
         left_cur   = left_ff;
         term_cur   = term_ff;
      end
   end

   assign busy     = (status_cur == cbd_pkg::STATUS_BUSY);
   assign acc_next = {acc_cur, hex.value};
   assign line_end = busy && (b == cbd_pkg::CharLf) &&
                     (phase_cur == cbd_pkg::PH_SIZE_CR || phase_cur == cbd_pkg::PH_EXT_CR);

   // Next parser position.
   always_comb begin
      phase_in = phase_cur;
      if (busy) begin
         unique case (phase_cur) inside
            cbd_pkg::PH_SIZE: begin
               if (b == cbd_pkg::CharSemi) begin
                  phase_in = cbd_pkg::PH_EXT;
               end else if (b == cbd_pkg::CharCr) begin
                  phase_in = cbd_pkg::PH_SIZE_CR;
               end
            end
            cbd_pkg::PH_SIZE_CR, cbd_pkg::PH_EXT_CR: begin
               if (line_end) begin
                  if (digit_cur) begin
                     phase_in = (acc_cur == '0) ? cbd_pkg::PH_TRAIL : cbd_pkg::PH_DATA;
                  end
               end else if (phase_cur == cbd_pkg::PH_EXT_CR && b != cbd_pkg::CharCr) begin
                  phase_in = cbd_pkg::PH_EXT;
               end
            end
            cbd_pkg::PH_EXT: begin
               if (b == cbd_pkg::CharCr) begin
                  phase_in = cbd_pkg::PH_EXT_CR;
               end
            end
            cbd_pkg::PH_DATA: begin
               if (left_cur == 32'd1) begin
                  phase_in = cbd_pkg::PH_DATA_CR;
               end
            end
            cbd_pkg::PH_DATA_CR: begin
               if (b == cbd_pkg::CharCr) begin
                  phase_in = cbd_pkg::PH_DATA_LF;
               end
            end
            cbd_pkg::PH_DATA_LF: begin
               if (b == cbd_pkg::CharLf) begin
                  phase_in = cbd_pkg::PH_SIZE;
               end
            end
            cbd_pkg::PH_TRAIL: begin
               phase_in = cbd_pkg::PH_TRAIL;
            end
            default: begin
               phase_in = cbd_pkg::PH_SIZE;
            end
         endcase
      end
   end

   // Counters, status and the payload flag.
   always_comb begin
      acc_in     = acc_cur;
      digit_in   = digit_cur;
      left_in    = left_cur;
      term_in    = term_cur;
      status_in  = status_cur;
      data_valid = 1'b0;
      if (busy) begin
         unique case (phase_cur) inside
            cbd_pkg::PH_SIZE: begin
               if (b != cbd_pkg::CharSemi && b != cbd_pkg::CharCr &&
                   b != cbd_pkg::CharSpace && b != cbd_pkg::CharTab) begin
                  if (!hex.valid) begin
                     status_in = cbd_pkg::STATUS_ERROR;
                  end else begin
                     acc_in   = acc_next[31:0];
                     digit_in = 1'b1;
                     if (acc_next > {4'd0, limit_ff}) begin
                        status_in = cbd_pkg::STATUS_ERROR;
                     end
                  end
               end
            end
            cbd_pkg::PH_SIZE_CR, cbd_pkg::PH_EXT_CR: begin
               if (line_end) begin
                  acc_in   = '0;
                  digit_in = 1'b0;
                  if (!digit_cur) begin
                     status_in = cbd_pkg::STATUS_ERROR;
                  end else if (acc_cur == '0) begin
                     // The CRLF closing the last size line counts toward the terminator.
                     term_in = cbd_pkg::TermSizeLine;
                  end else begin
                     left_in = acc_cur;
                  end
               end else if (phase_cur == cbd_pkg::PH_SIZE_CR) begin
                  status_in = cbd_pkg::STATUS_ERROR;
               end
            end
            cbd_pkg::PH_EXT: begin
               acc_in = acc_cur;
            end
            cbd_pkg::PH_DATA: begin
               data_valid = 1'b1;
               left_in    = left_cur - 32'd1;
            end
            cbd_pkg::PH_DATA_CR: begin
               if (b != cbd_pkg::CharCr) begin
                  status_in = cbd_pkg::STATUS_ERROR;
               end
            end
            cbd_pkg::PH_DATA_LF: begin
               if (b != cbd_pkg::CharLf) begin
                  status_in = cbd_pkg::STATUS_ERROR;
               end
            end
            cbd_pkg::PH_TRAIL: begin
               // Even counts expect CR, odd counts expect LF.
               if (!term_cur[0]) begin
                  term_in = (b == cbd_pkg::CharCr) ? term_cur + 3'd1 : 3'd0;
               end else if (b == cbd_pkg::CharLf) begin
                  term_in = term_cur + 3'd1;
               end else begin
                  term_in = (b == cbd_pkg::CharCr) ? 3'd1 : 3'd0;
               end
               if (term_in >= cbd_pkg::TermFull) begin
                  status_in = cbd_pkg::STATUS_DONE;
               end
            end
            default: begin
               status_in = cbd_pkg::STATUS_ERROR;
            end
         endcase
      end
   end

   always_comb begin
      rsp_in.data_byte  = data_valid ? b : 8'd0;
      rsp_in.data_valid = data_valid;
      rsp_in.status     = status_in;
      rsp_valid_in      = advance ? stage.valid : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= cbd_pkg::PH_SIZE;
         status_ff    <= cbd_pkg::STATUS_BUSY;
         acc_ff       <= '0;
         digit_ff     <= 1'b0;
         left_ff      <= '0;
         term_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            phase_ff  <= phase_in;
            status_ff <= status_in;
            acc_ff    <= acc_in;
            digit_ff  <= digit_in;
            left_ff   <= left_in;
            term_ff   <= term_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= cbd_pkg::ChunkSizeLimitReset;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ hdl/http_chunked_body_decoder_unit.sv @@
// Top level of the HTTP chunked transfer body decoder.
`timescale 1ns / 1ps

// Decodes a chunked message body one byte per clock while rsp_ is not stalled:
// every accepted word gives exactly one result word, which goes from the input
// register through the decode stage into the result register and so to rsp_.
// A new word can be accepted in every cycle, because the hex digit step, the
// size limit compare and the payload countdown are all done in the single
// decode stage between the input register and the result register. A stall on
// the result side holds the result register and then the input register, which
// lowers req_ready. The size limit register is written through csr_ and takes
// effect for the next word; write it only while no word is in flight.
module http_chunked_body_decoder_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cbd_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cbd_pkg::rsp_type  rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [31:0]       csr_wdata
);

   cbd_pkg::stage_type stage;
   logic               advance;

   cbd_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .advance     (advance),
      .stage       (stage)
   );

   cbd_decoder u_decoder (
      .clock       (clock),
      .reset       (reset),
      .stage       (stage),
      .advance     (advance),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_wdata   (csr_wdata)
   );

endmodule

@@ hdl/cbd_checker.sv @@
// Port-level checks for the chunked body decoder, bound to the top level.
`timescale 1ns / 1ps

module cbd_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input cbd_pkg::rsp_type  rsp_payload
);

   // A result word that is not taken stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result word changed while stalled");

   // Reset leaves no result word pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word pending after reset");

   // Input stalls only when the result side is stalled.
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without a result stall");

   // Payload is only passed while decoding is still in progress.
   a_data_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.data_valid |->
         rsp_payload.status == cbd_pkg::STATUS_BUSY)
      else $error("payload word with final status");

   // Non-payload words carry a zero data byte.
   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.data_valid |-> rsp_payload.data_byte == 8'd0)
      else $error("data byte set on a non-payload word");

endmodule

bind http_chunked_body_decoder_unit cbd_checker u_cbd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
